// File: hdl/fcc_pkg.sv
// Package for the frame checksum checker.
// Holds the shared constants, the result word type and the checksum update function.
// Depends on nothing.
package fcc_pkg;

    localparam logic [15:0] CK_INIT     = 16'h147A;
    localparam logic [7:0]  CK_STUFF    = 8'hFE;
    localparam logic [8:0]  FRAME_EXTRA = 9'd7;
    localparam logic [7:0]  POS_MAX     = 8'hFF;
    localparam logic [7:0]  POS_CMD     = 8'd2;
    localparam logic [8:0]  POS_DATA    = 9'd3;
    localparam logic [8:0]  POS_CK_LOW  = 9'd4;
    localparam logic [7:0]  DLEN_RESET  = 8'd0;

    typedef struct packed {
        logic        checksum_match;
        logic        length_mismatch;
        logic [15:0] computed_checksum;
        logic [7:0]  command;
    } t_result;

    // Rotate left by one, invert, then add the own high byte and the new byte.
    function automatic logic [15:0] ck_update(input logic [15:0] sum, input logic [7:0] b);
        logic [15:0] r;
        begin
            r = ~{sum[14:0], sum[15]};
            ck_update = r + {8'd0, r[15:8]} + {8'd0, b};
        end
    endfunction

endpackage

// File: hdl/fcc_frame_state.sv
// Frame state of the checksum checker: byte position, running checksum, stuffing
// flag and captured bytes, plus the result word formed on the last byte.
// Depends on fcc_pkg.
module fcc_frame_state (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last_byte,
    input  logic [7:0]      i_data_length,
    output fcc_pkg::t_result o_result
);
    import fcc_pkg::*;

    logic [7:0]  r_pos;
    logic [15:0] r_sum;
    logic        r_skip;
    logic [7:0]  r_rx_high;
    logic [7:0]  r_rx_low;
    logic [7:0]  r_cmd;

    logic [7:0]  n_pos;
    logic [15:0] n_sum;
    logic        n_skip;
    logic [7:0]  n_rx_high;
    logic [7:0]  n_rx_low;
    logic [7:0]  n_cmd;

    logic        saturated;
    logic [8:0]  pos_ext;
    logic [8:0]  dlen_ext;
    logic        len_bad;

    assign saturated = (r_pos == POS_MAX);
    assign pos_ext   = {1'b0, r_pos};
    assign dlen_ext  = {1'b0, i_data_length};

    always_comb begin
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_skip    = r_skip;
        n_rx_high = r_rx_high;
        n_rx_low  = r_rx_low;
        n_cmd     = r_cmd;
        if (!saturated) begin
            if (r_pos == POS_CMD) begin
                n_cmd = i_data_byte;
                n_sum = ck_update(CK_INIT, i_data_byte);
            end else if (pos_ext >= POS_DATA && pos_ext < POS_DATA + dlen_ext) begin
                if (r_skip) begin
                    n_skip = 1'b0;
                end else begin
                    n_sum = ck_update(r_sum, i_data_byte);
                    if (i_data_byte == CK_STUFF) begin
                        n_skip = 1'b1;
                    end
                end
            end else if (pos_ext == POS_DATA + dlen_ext) begin
                n_rx_high = i_data_byte;
            end else if (pos_ext == POS_CK_LOW + dlen_ext) begin
                n_rx_low = i_data_byte;
            end
            n_pos = r_pos + 8'd1;
        end
    end

    assign len_bad = saturated || (pos_ext + 9'd1 != dlen_ext + FRAME_EXTRA);

    always_comb begin
        o_result.length_mismatch   = len_bad;
        o_result.checksum_match    = !len_bad && ({n_rx_high, n_rx_low} == n_sum);
        o_result.computed_checksum = n_sum;
        o_result.command           = n_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_sum     <= CK_INIT;
            r_skip    <= 1'b0;
            r_rx_high <= '0;
            r_rx_low  <= '0;
            r_cmd     <= '0;
        end else if (i_step) begin
            if (i_last_byte) begin
                r_pos     <= '0;
                r_sum     <= CK_INIT;
                r_skip    <= 1'b0;
                r_rx_high <= '0;
                r_rx_low  <= '0;
                r_cmd     <= '0;
            end else begin
                r_pos     <= n_pos;
                r_sum     <= n_sum;
                r_skip    <= n_skip;
                r_rx_high <= n_rx_high;
                r_rx_low  <= n_rx_low;
                r_cmd     <= n_cmd;
            end
        end
    end

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last_byte |=> r_pos == '0 && r_sum == CK_INIT && !r_skip)
        else $error("frame state not cleared after last word");

    a_pos_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_last_byte && r_pos != POS_MAX |=> r_pos == $past(r_pos) + 8'd1)
        else $error("byte position did not advance");

    a_sat_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_last_byte && r_pos == POS_MAX |=> r_pos == POS_MAX && $stable(r_sum))
        else $error("saturated frame state changed");

    a_match_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.checksum_match |-> !o_result.length_mismatch)
        else $error("match reported with a length error");
`endif

endmodule

// File: hdl/frame_checksum_checker.sv
// Pipeline: a word is registered on acceptance, and the result of a last word is
// captured into the output register when that registered word steps the frame state.
// Throughput: one word per cycle; the pipeline holds only while a result is stalled.
// Reset: synchronous, active low; clears the frame state, the data length register
// and both valid flags.
// Top level of the frame checksum checker; depends on fcc_pkg and fcc_frame_state.
module frame_checksum_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_checksum_match,
    output logic        o_length_mismatch,
    output logic [15:0] o_computed_checksum,
    output logic [7:0]  o_command,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data
);
    import fcc_pkg::*;

    logic [7:0]  r_data_length;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out;
    t_result     step_result;
    logic        advance;

    assign advance    = !(r_out_valid && i_out_stall);
    assign o_in_stall = !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_length <= DLEN_RESET;
        end else if (i_cfg_we) begin
            r_data_length <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    fcc_frame_state u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (r_in_valid && advance),
        .i_data_byte   (r_in_byte),
        .i_last_byte   (r_in_last),
        .i_data_length (r_data_length),
        .o_result      (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && r_in_last) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_checksum_match    = r_out.checksum_match;
    assign o_length_mismatch   = r_out.length_mismatch;
    assign o_computed_checksum = r_out.computed_checksum;
    assign o_command           = r_out.command;

`ifndef SYNTHESIS
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(r_out))
        else $error("stalled result changed");

    a_stall_only_on_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid) && $past(r_in_last))
        else $error("result without a last word");

    a_cfg_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> r_data_length == $past(i_cfg_data))
        else $error("data length write lost");
`endif

endmodule

// File: tb/frame_checksum_checker_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for frame_checksum_checker: sends whole frames word by word with
// random gaps and output stalls, predicts each frame verdict and compares it field by field.
// Depends on fcc_pkg and the frame_checksum_checker RTL.
module frame_checksum_checker_test;
    import fcc_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 150;

    typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_SHORT, FRAME_LONG} t_frame_kind;

    class frame_verdict_model;
        int unsigned length_cfg;
        int unsigned count;
        logic [15:0] acc;
        logic        drop_next;
        logic [7:0]  sum_hi;
        logic [7:0]  sum_lo;
        logic [7:0]  cmd;
        t_result     verdicts_due[$];
        int          errors;

        function new();
            length_cfg = DLEN_RESET;
            errors = 0;
            restart();
        endfunction

        function void restart();
            count = 0;
            acc = CK_INIT;
            drop_next = 1'b0;
            sum_hi = 8'h00;
            sum_lo = 8'h00;
            cmd = 8'h00;
        endfunction

        static function logic [15:0] mix(input logic [15:0] s, input logic [7:0] b);
            logic [15:0] t;
            t = {s[14:0], s[15]} ^ 16'hFFFF;
            return t + {8'h00, t[15:8]} + {8'h00, b};
        endfunction

        function void take_byte(input logic [7:0] b, input logic last);
            int unsigned p;
            logic        full;
            t_result     v;
            p = count;
            full = (p == POS_MAX);
            if (!full) begin
                if (p == POS_CMD) begin
                    cmd = b;
                    acc = mix(CK_INIT, b);
                end else if (p >= POS_DATA && p < POS_DATA + length_cfg) begin
                    if (drop_next) begin
                        drop_next = 1'b0;
                    end else begin
                        acc = mix(acc, b);
                        drop_next = (b == CK_STUFF);
                    end
                end else if (p == POS_DATA + length_cfg) begin
                    sum_hi = b;
                end else if (p == POS_CK_LOW + length_cfg) begin
                    sum_lo = b;
                end
                count = p + 1;
            end
            if (last) begin
                v.length_mismatch = full || (p + 1 != length_cfg + FRAME_EXTRA);
                v.checksum_match = !v.length_mismatch && ({sum_hi, sum_lo} == acc);
                v.computed_checksum = acc;
                v.command = cmd;
                verdicts_due.push_back(v);
                restart();
            end
        endfunction

        function void compare_field(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_verdict(input logic m, input logic l, input logic [15:0] c,
                                    input logic [7:0] k);
            t_result want;
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %b %b %h %h",
                         $time, m, l, c, k);
                errors++;
            end else begin
                want = verdicts_due.pop_front();
                compare_field("checksum_match", want.checksum_match, m);
                compare_field("length_mismatch", want.length_mismatch, l);
                compare_field("computed_checksum", want.computed_checksum, c);
                compare_field("command", want.command, k);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_checksum_match;
    logic        o_length_mismatch;
    logic [15:0] o_computed_checksum;
    logic [7:0]  o_command;

    logic        hold_req = 1'b0;
    logic        hold_on = 1'b0;
    int unsigned idle_run = 0;
    int unsigned n_bytes = 0;
    logic [7:0]  frame_q[$];
    frame_verdict_model model;

    frame_checksum_checker dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_data_byte         (i_data_byte),
        .i_last_byte         (i_last_byte),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_checksum_match    (o_checksum_match),
        .o_length_mismatch   (o_length_mismatch),
        .o_computed_checksum (o_computed_checksum),
        .o_command           (o_command),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Everything changes on the rising edge, so the handshakes are stable at the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                model.take_byte(i_data_byte, i_last_byte);
            end
            if (o_out_valid && !i_out_stall) begin
                model.match_verdict(o_checksum_match, o_length_mismatch,
                                    o_computed_checksum, o_command);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_run = 0;
            end else begin
                idle_run++;
            end
            if (idle_run == IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        int unsigned r;
        int unsigned n;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                hold_on = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_on = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    i_out_stall <= 1'b0;
                    n = $urandom_range(20, 60);
                end else begin
                    i_out_stall <= ($urandom_range(0, 2) == 0);
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                    : $urandom_range(1, 3);
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r < 2) return CK_STUFF;
        if (r == 2) return 8'hFF;
        if (r == 3) return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void frame_from(input logic [7:0] cmd, input logic [7:0] body[$]);
        logic [15:0] s;
        logic        skip;
        frame_q.delete();
        frame_q.push_back(pick_byte());
        frame_q.push_back(pick_byte());
        frame_q.push_back(cmd);
        s = frame_verdict_model::mix(CK_INIT, cmd);
        skip = 1'b0;
        foreach (body[k]) begin
            if (skip) begin
                skip = 1'b0;
            end else begin
                s = frame_verdict_model::mix(s, body[k]);
                skip = (body[k] == CK_STUFF);
            end
            frame_q.push_back(body[k]);
        end
        frame_q.push_back(s[15:8]);
        frame_q.push_back(s[7:0]);
        frame_q.push_back(pick_byte());
        frame_q.push_back(pick_byte());
    endfunction

    function automatic void build_frame(input int unsigned dl, input t_frame_kind kind);
        logic [7:0]  body[$];
        int unsigned idx;
        repeat (dl) body.push_back(pick_byte());
        frame_from(pick_byte(), body);
        case (kind)
            FRAME_BAD_SUM: begin
                idx = 3 + dl + $urandom_range(0, 1);
                frame_q[idx] = frame_q[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            FRAME_SHORT: begin
                idx = $urandom_range(1, frame_q.size() - 1);
                while (frame_q.size() > idx) frame_q.delete(frame_q.size() - 1);
            end
            FRAME_LONG: begin
                repeat ($urandom_range(1, 4)) frame_q.push_back(pick_byte());
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
        n_bytes++;
    endtask

    task automatic sender_gap(input logic tight);
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        if (tight || r < 60) begin
            n = 0;
        end else if (r < 90) begin
            n = $urandom_range(1, 3);
        end else begin
            n = $urandom_range(4, 20);
        end
        if (n != 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input logic tight);
        for (int i = 0; i < frame_q.size(); i++) begin
            sender_gap(tight);
            send_byte(frame_q[i], i == frame_q.size() - 1);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (model.verdicts_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_length(input logic [7:0] v);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model.length_cfg = v;
    endtask

    initial begin
        logic [7:0]  body[$];
        int unsigned r;
        int unsigned left;
        t_frame_kind kind;
        model = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Length zero after reset: a clean frame at the byte extremes, then a one-word frame.
        body.delete();
        frame_from(8'hFF, body);
        frame_q[0] = 8'h00;
        frame_q[1] = 8'hFF;
        send_frame(1'b0);
        frame_q.delete();
        frame_q.push_back(8'hFF);
        send_frame(1'b0);

        // Stuffing: a skipped byte after 0xFE, and 0xFE as the final data byte.
        set_length(8'd2);
        body.delete();
        body.push_back(CK_STUFF);
        body.push_back(8'h00);
        frame_from(8'h00, body);
        send_frame(1'b0);
        body.delete();
        body.push_back(8'h5A);
        body.push_back(CK_STUFF);
        frame_from(8'hA5, body);
        send_frame(1'b0);

        // Largest length that can match, then a frame long enough to saturate the counter.
        set_length(8'd248);
        build_frame(248, FRAME_GOOD);
        send_frame(1'b0);
        build_frame(248, FRAME_LONG);
        send_frame(1'b0);

        set_length(8'd255);
        repeat (3) begin
            build_frame($urandom_range(0, 6), t_frame_kind'($urandom_range(0, 3)));
            send_frame(1'b0);
        end

        // Short frames back to back while the receiver holds off, so the input stalls.
        set_length(8'd0);
        hold_req = 1'b1;
        wait (hold_on);
        repeat (12) begin
            frame_q.delete();
            repeat ($urandom_range(1, 2)) frame_q.push_back(pick_byte());
            send_frame(1'b1);
        end
        wait_drained();

        left = 0;
        while (n_bytes < 850) begin
            if (left == 0) begin
                r = $urandom_range(0, 9);
                set_length(r < 7 ? 8'($urandom_range(0, 8)) : 8'($urandom_range(9, 24)));
                left = $urandom_range(4, 10);
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
                kind = FRAME_GOOD;
            end else if (r < 75) begin
                kind = FRAME_BAD_SUM;
            end else if (r < 88) begin
                kind = FRAME_SHORT;
            end else begin
                kind = FRAME_LONG;
            end
            build_frame(model.length_cfg, kind);
            send_frame($urandom_range(0, 3) == 0);
            left--;
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (model.verdicts_due.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time,
                     model.verdicts_due.size());
        end
        if (model.errors == 0 && model.verdicts_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
